@@ hdl/fpec_pkg.sv @@
// Package for the flash program/erase controller.
// Opcodes, register selects, key stages, keys and flash geometry constants.
`default_nettype none
package fpec_pkg;
  localparam int PAGE_COUNT     = 8;
  localparam int PAGE_HALFWORDS = 1024;
  localparam int FLASH_WORDS    = PAGE_COUNT * PAGE_HALFWORDS;
  localparam int IDX_W          = $clog2(FLASH_WORDS);
  localparam int PAGE_W         = $clog2(PAGE_COUNT);
  localparam int OFF_W          = $clog2(PAGE_HALFWORDS);

  typedef logic [2:0]  opcode_t;
  typedef logic [1:0]  sel_t;
  typedef logic [1:0]  key_stage_t;

  localparam opcode_t OP_REG_RD   = 3'd0;
  localparam opcode_t OP_REG_WR   = 3'd1;
  localparam opcode_t OP_FLASH_RD = 3'd2;
  localparam opcode_t OP_FLASH_WR = 3'd3;
  localparam opcode_t OP_TICK     = 3'd4;

  localparam sel_t REG_KEY    = 2'd0;
  localparam sel_t REG_STATUS = 2'd1;
  localparam sel_t REG_CTRL   = 2'd2;
  localparam sel_t REG_ADDR   = 2'd3;

  localparam key_stage_t KS_WAIT1  = 2'd0;
  localparam key_stage_t KS_WAIT2  = 2'd1;
  localparam key_stage_t KS_OPEN   = 2'd2;
  localparam key_stage_t KS_LOCKED = 2'd3;

  localparam logic [31:0] KEY_ONE = 32'h4567_0123;
  localparam logic [31:0] KEY_TWO = 32'hCDEF_89AB;

  localparam logic [0:0] CFG_ERASE_TICKS = 1'b0;
  localparam logic [0:0] CFG_PROG_TICKS  = 1'b1;
endpackage
`default_nettype wire

@@ hdl/fpec_if.sv @@
// Valid/ready channel interfaces for the flash controller.
// Depends on fpec_pkg.
`default_nettype none
interface fpec_in_if;
  logic                    valid;
  logic                    ready;
  fpec_pkg::opcode_t       opcode;
  fpec_pkg::sel_t          reg_select;
  logic [12:0]             flash_index;
  logic [31:0]             write_data;
  modport source (output valid, opcode, reg_select, flash_index, write_data, input ready);
  modport sink   (input valid, opcode, reg_select, flash_index, write_data, output ready);
endinterface

interface fpec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        busy_res;
  logic        accepted;
  modport source (output valid, read_data, busy_res, accepted, input ready);
  modport sink   (input valid, read_data, busy_res, accepted, output ready);
endinterface
`default_nettype wire

@@ hdl/fpec_ram.sv @@
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module fpec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/flash_program_erase_controller.sv @@
// Flash program/erase controller with two-key unlock, flash array in one RAM.
// Channels: in_if carries bus accesses and ticks (opcode, reg_select,
// flash_index, write_data); out_if returns one result per item (read_data,
// busy_res, accepted). Both use valid/ready; a transfer happens when both
// are high at a rising edge of clk.
// Configuration: cfg_we/cfg_index/cfg_wdata write erase_ticks (index 0) and program_ticks
// (index 1), only while the block is idle: a rule for the user, not enforced by the block.
// Flow: the flash RAM read starts at the input transfer edge; the next cycle
// (S_EXEC) decodes, does the read-modify-write and loads the output register.
// The next item is taken once the block is back in S_IDLE and the result
// register is free or being emptied, so no new item is taken while one is
// in S_EXEC.
// Reset (rst_n low, synchronous): control locked, registers cleared, tick
// settings set to erase 4096 and program 4, then a clearing pass writes 0xFFFF
// to all 8192 halfwords, one per cycle; no item is taken during this pass.
// A stalled receiver holds the result in the output register; no new item
// is taken until that result is transferred.
`default_nettype none
module flash_program_erase_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fpec_in_if.sink          in_if,
  fpec_out_if.source       out_if,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  import fpec_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_ptr_r;
  logic [23:0]      erase_ticks_r;
  logic [15:0]      prog_ticks_r;
  key_stage_t       key_stage_r, key_stage_nxt;
  logic             pg_r, pg_nxt, per_r, per_nxt, strt_r, strt_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic             perr_r, perr_nxt;
  logic [23:0]      busy_cnt_r, busy_cnt_nxt;
  logic [OFF_W:0]   erase_ptr_r, erase_ptr_nxt;

  opcode_t          op_r;
  sel_t             sel_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      data_r;

  logic             out_valid_r;
  logic [31:0]      out_rd_r, rd_nxt;
  logic             out_busy_r;
  logic             out_acc_r, acc_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata, mem_rdata;

  logic             in_xfer, busy, unlocked;
  logic [23:0]      erase_len;
  logic [PAGE_W-1:0] page;

  fpec_ram #(.WIDTH(16), .DEPTH(FLASH_WORDS)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_if.ready      = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_xfer          = in_if.valid && in_if.ready;
  assign mem_raddr        = in_if.flash_index[IDX_W-1:0];
  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = out_rd_r;
  assign out_if.busy_res  = out_busy_r;
  assign out_if.accepted  = out_acc_r;

  assign busy      = busy_cnt_r != 24'd0;
  assign unlocked  = key_stage_r == KS_OPEN;
  assign page      = addr_r[1+OFF_W +: PAGE_W];
  assign erase_len = (erase_ticks_r < 24'(PAGE_HALFWORDS)) ? 24'(PAGE_HALFWORDS)
                                                           : erase_ticks_r;

  always_comb begin
    state_nxt     = state_r;
    key_stage_nxt = key_stage_r;
    pg_nxt        = pg_r;
    per_nxt       = per_r;
    strt_nxt      = strt_r;
    addr_nxt      = addr_r;
    perr_nxt      = perr_r;
    busy_cnt_nxt  = busy_cnt_r;
    erase_ptr_nxt = erase_ptr_r;
    rd_nxt        = 32'd0;
    acc_nxt       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = 16'hFFFF;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_r;
        if (clr_ptr_r == IDX_W'(FLASH_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_REG_RD: begin
            if (!busy || sel_r == REG_STATUS) begin
              acc_nxt = 1'b1;
              case (sel_r)
                REG_STATUS: rd_nxt = {29'd0, perr_r, 1'b0, busy};
                REG_CTRL:   rd_nxt = {24'd0, !unlocked, strt_r, 4'd0, per_r, pg_r};
                REG_ADDR:   rd_nxt = addr_r;
                default:    rd_nxt = 32'd0;
              endcase
            end
          end
          OP_REG_WR: begin
            if (!busy || sel_r == REG_STATUS) begin
              case (sel_r)
                REG_KEY: begin
                  case (key_stage_r)
                    KS_WAIT1: begin
                      key_stage_nxt = (data_r == KEY_ONE) ? KS_WAIT2 : KS_LOCKED;
                      acc_nxt       = 1'b1;
                    end
                    KS_WAIT2: begin
                      key_stage_nxt = (data_r == KEY_TWO) ? KS_OPEN : KS_LOCKED;
                      acc_nxt       = 1'b1;
                    end
                    KS_LOCKED: acc_nxt = 1'b1;
                    default:   acc_nxt = 1'b0;
                  endcase
                end
                REG_STATUS: begin
                  acc_nxt = 1'b1;
                  if (data_r[2]) begin
                    perr_nxt = 1'b0;
                  end
                end
                REG_CTRL: begin
                  if (unlocked) begin
                    acc_nxt  = 1'b1;
                    pg_nxt   = data_r[0];
                    per_nxt  = data_r[1];
                    strt_nxt = 1'b0;
                    if (data_r[6] && data_r[1]) begin
                      strt_nxt      = 1'b1;
                      busy_cnt_nxt  = erase_len;
                      erase_ptr_nxt = '0;
                    end
                    if (data_r[7]) begin
                      key_stage_nxt = KS_WAIT1;
                    end
                  end
                end
                default: begin
                  if (unlocked) begin
                    acc_nxt  = 1'b1;
                    addr_nxt = data_r;
                  end
                end
              endcase
            end
          end
          OP_FLASH_RD: begin
            if (!busy) begin
              acc_nxt = 1'b1;
              rd_nxt  = {16'd0, mem_rdata};
            end
          end
          OP_FLASH_WR: begin
            if (!busy && unlocked && pg_r) begin
              acc_nxt = 1'b1;
              if (mem_rdata == 16'hFFFF) begin
                mem_we       = 1'b1;
                mem_wdata    = data_r[15:0];
                busy_cnt_nxt = (prog_ticks_r != 16'd0) ? {8'd0, prog_ticks_r} : 24'd1;
              end else begin
                perr_nxt = 1'b1;
              end
            end
          end
          OP_TICK: begin
            acc_nxt = 1'b1;
            if (busy) begin
              if (strt_r && erase_ptr_r < (OFF_W+1)'(PAGE_HALFWORDS)) begin
                mem_we        = 1'b1;
                mem_waddr     = {page, erase_ptr_r[OFF_W-1:0]};
                erase_ptr_nxt = erase_ptr_r + 1'b1;
              end
              busy_cnt_nxt = busy_cnt_r - 24'd1;
              if (busy_cnt_r == 24'd1) begin
                strt_nxt = 1'b0;
              end
            end
          end
          default: acc_nxt = 1'b0;
        endcase
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_ptr_r     <= '0;
      erase_ticks_r <= 24'd4096;
      prog_ticks_r  <= 16'd4;
      key_stage_r   <= KS_WAIT1;
      pg_r          <= 1'b0;
      per_r         <= 1'b0;
      strt_r        <= 1'b0;
      addr_r        <= 32'd0;
      perr_r        <= 1'b0;
      busy_cnt_r    <= 24'd0;
      erase_ptr_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_ptr_r     <= clr_ptr_r + 1'b1;
      key_stage_r   <= key_stage_nxt;
      pg_r          <= pg_nxt;
      per_r         <= per_nxt;
      strt_r        <= strt_nxt;
      addr_r        <= addr_nxt;
      perr_r        <= perr_nxt;
      busy_cnt_r    <= busy_cnt_nxt;
      erase_ptr_r   <= erase_ptr_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_ERASE_TICKS) begin
          erase_ticks_r <= cfg_wdata;
        end else begin
          prog_ticks_r <= cfg_wdata[15:0];
        end
      end
      if (state_r == S_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_if.opcode;
      sel_r  <= in_if.reg_select;
      idx_r  <= in_if.flash_index[IDX_W-1:0];
      data_r <= in_if.write_data;
    end
    if (state_r == S_EXEC) begin
      out_rd_r   <= rd_nxt;
      out_busy_r <= busy_cnt_nxt != 24'd0;
      out_acc_r  <= acc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_strt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strt_r |-> busy_cnt_r != 24'd0) else $error("erase start set while not busy");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    erase_ptr_r <= (OFF_W+1)'(PAGE_HALFWORDS)) else $error("erase pointer past page");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r && !in_if.ready)
    else $error("activity during clearing pass");
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid_r) else $error("result not loaded");
`endif
endmodule
`default_nettype wire

@@ dv/fpec_tb_if.sv @@
// Testbench copy point for channel interfaces: none defined here.
// The channel interfaces come from hdl/fpec_if.sv; this file holds shared tb types.
// Uses no other package.
`timescale 1ns / 1ps
package fpec_tb_pkg;
  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  reg_select;
    logic [12:0] flash_index;
    logic [31:0] write_data;
  } access_t;
  typedef struct packed {
    logic [31:0] read_data;
    logic        busy_res;
    logic        accepted;
  } reply_t;
endpackage

@@ dv/tb_flash_program_erase_controller.sv @@
// Testbench for flash_program_erase_controller: directed and random bus accesses,
// a behavioral controller model predicts each reply, a monitor compares in order.
// Depends on fpec_pkg, fpec_if.sv and fpec_tb_pkg.
`timescale 1ns / 1ps
module tb_flash_program_erase_controller;
  import fpec_pkg::*;
  import fpec_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  fpec_in_if in_ch();
  fpec_out_if out_ch();

  flash_program_erase_controller u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller model state
  logic [15:0] mdl_flash [FLASH_WORDS];
  key_stage_t  mdl_key;
  logic [2:0]  mdl_ctrl;
  logic [31:0] mdl_addr;
  logic        mdl_perr;
  logic [23:0] mdl_busy;
  logic [12:0] mdl_eptr;
  logic [23:0] mdl_erase_ticks;
  logic [15:0] mdl_prog_ticks;

  reply_t replies_due[$];
  int mismatches = 0;
  int cycles = 0;
  int n_replies = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  localparam int LIMIT = 3000000;

  function automatic logic [31:0] reg_view(sel_t sel);
    case (sel)
      REG_STATUS: reg_view = {29'd0, mdl_perr, 1'b0, mdl_busy != 0};
      REG_CTRL: reg_view = {24'd0, mdl_key != KS_OPEN, mdl_ctrl[2], 4'd0, mdl_ctrl[1:0]};
      REG_ADDR: reg_view = mdl_addr;
      default: reg_view = '0;
    endcase
  endfunction

  function automatic logic reg_store(sel_t sel, logic [31:0] v);
    logic [23:0] t;
    reg_store = 1'b1;
    case (sel)
      REG_KEY: begin
        if (mdl_key == KS_WAIT1) mdl_key = (v == KEY_ONE) ? KS_WAIT2 : KS_LOCKED;
        else if (mdl_key == KS_WAIT2) mdl_key = (v == KEY_TWO) ? KS_OPEN : KS_LOCKED;
        else reg_store = (mdl_key == KS_LOCKED);
      end
      REG_STATUS: if (v[2]) mdl_perr = 1'b0;
      REG_CTRL: begin
        if (mdl_key != KS_OPEN) return 1'b0;
        mdl_ctrl = {1'b0, v[1:0]};
        if (v[6] && v[1]) begin
          t = (mdl_erase_ticks < PAGE_HALFWORDS) ? 24'(PAGE_HALFWORDS) : mdl_erase_ticks;
          mdl_ctrl[2] = 1'b1;
          mdl_busy = t;
          mdl_eptr = '0;
        end
        if (v[7]) mdl_key = KS_WAIT1;
      end
      default: begin
        if (mdl_key != KS_OPEN) return 1'b0;
        mdl_addr = v;
      end
    endcase
  endfunction

  function automatic reply_t controller_reply(access_t a);
    reply_t r;
    logic busy;
    logic [2:0] page;
    busy = mdl_busy != 0;
    r = '0;
    case (a.opcode)
      OP_REG_RD: if (!busy || a.reg_select == REG_STATUS) begin
        r.read_data = reg_view(a.reg_select);
        r.accepted = 1'b1;
      end
      OP_REG_WR: if (!busy || a.reg_select == REG_STATUS)
        r.accepted = reg_store(a.reg_select, a.write_data);
      OP_FLASH_RD: if (!busy) begin
        r.read_data = {16'd0, mdl_flash[a.flash_index]};
        r.accepted = 1'b1;
      end
      OP_FLASH_WR: if (!busy && mdl_key == KS_OPEN && mdl_ctrl[0]) begin
        r.accepted = 1'b1;
        if (mdl_flash[a.flash_index] == 16'hFFFF) begin
          mdl_flash[a.flash_index] = a.write_data[15:0];
          mdl_busy = (mdl_prog_ticks != 0) ? 24'(mdl_prog_ticks) : 24'd1;
        end else mdl_perr = 1'b1;
      end
      OP_TICK: begin
        r.accepted = 1'b1;
        if (mdl_busy != 0) begin
          if (mdl_ctrl[2] && mdl_eptr < PAGE_HALFWORDS) begin
            page = mdl_addr[13:11];
            mdl_flash[{page, mdl_eptr[9:0]}] = 16'hFFFF;
            mdl_eptr++;
          end
          mdl_busy--;
          if (mdl_busy == 0) mdl_ctrl[2] = 1'b0;
        end
      end
      default: ;
    endcase
    r.busy_res = mdl_busy != 0;
    return r;
  endfunction

  task automatic send_access(access_t a);
    in_ch.valid <= 1'b1;
    {in_ch.opcode, in_ch.reg_select, in_ch.flash_index, in_ch.write_data} <= a;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    replies_due.push_back(controller_reply(a));
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
  endtask

  task automatic send_op(opcode_t op, sel_t sel, logic [12:0] idx, logic [31:0] d);
    send_access('{op, sel, idx, d});
  endtask

  task automatic drain(int extra);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [23:0] v);
    drain(8);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ERASE_TICKS) mdl_erase_ticks = v;
    else mdl_prog_ticks = v[15:0];
    @(posedge clk);
  endtask

  task automatic unlock();
    send_op(OP_REG_WR, REG_KEY, '0, KEY_ONE);
    send_op(OP_REG_WR, REG_KEY, '0, KEY_TWO);
  endtask

  task automatic tick_until_idle();
    while (mdl_busy != 0) send_op(OP_TICK, '0, '0, '0);
  endtask

  task automatic test_directed();
    send_op(OP_REG_RD, REG_CTRL, '0, '0);
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h1);
    send_op(OP_FLASH_RD, '0, 13'h1FFF, '0);
    send_op(3'd5, REG_ADDR, 13'h1FFF, '1);
    send_op(3'd7, '0, '0, '0);
    send_op(OP_REG_RD, REG_STATUS, '0, '0);
  endtask

  task automatic test_wrong_key();
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h80);
    send_op(OP_REG_WR, REG_KEY, '0, 32'h1234);
    send_op(OP_REG_WR, REG_KEY, '0, KEY_ONE);
    send_op(OP_REG_RD, REG_CTRL, '0, '0);
  endtask

  task automatic test_program_erase();
    write_cfg(CFG_ERASE_TICKS, 24'd1024);
    write_cfg(CFG_PROG_TICKS, 24'd0);
    unlock();
    send_op(OP_REG_WR, REG_KEY, '0, KEY_ONE);
    send_op(OP_REG_WR, REG_ADDR, '0, 32'hFFFF_FFFF);
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h1);
    send_op(OP_FLASH_WR, '0, 13'h1FFF, 32'hFFFF_0000);
    send_op(OP_REG_RD, REG_ADDR, '0, '0);
    send_op(OP_TICK, '0, '0, '0);
    send_op(OP_FLASH_WR, '0, 13'h1FFF, 32'h1234);
    send_op(OP_REG_RD, REG_STATUS, '0, '0);
    send_op(OP_REG_WR, REG_STATUS, '0, 32'h4);
    send_op(OP_FLASH_RD, '0, 13'h1FFF, '0);
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h40);
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h42);
    send_op(OP_REG_RD, REG_CTRL, '0, '0);
    send_op(OP_FLASH_RD, '0, '0, '0);
    send_op(OP_REG_WR, REG_ADDR, '0, '0);
    tick_until_idle();
    send_op(OP_FLASH_RD, '0, 13'h1FFF, '0);
    send_op(OP_REG_WR, REG_CTRL, '0, 32'h80);
    send_op(OP_REG_RD, REG_CTRL, '0, '0);
    write_cfg(CFG_ERASE_TICKS, 24'hFFFFFF);
    write_cfg(CFG_PROG_TICKS, 24'hFFFF);
  endtask

  task automatic random_access();
    access_t a;
    int k;
    a.opcode = 3'($urandom_range(4));
    if ($urandom_range(19) == 0) a.opcode = 3'($urandom_range(7, 5));
    a.reg_select = 2'($urandom_range(3));
    a.flash_index = $urandom_range(15) < 12 ? 13'($urandom_range(63)) : 13'($urandom);
    a.write_data = $urandom;
    k = $urandom_range(9);
    if (a.opcode == OP_REG_WR && a.reg_select == REG_KEY && k < 8)
      a.write_data = (mdl_key == KS_WAIT1) ? KEY_ONE : KEY_TWO;
    if (a.opcode == OP_REG_WR && a.reg_select == REG_CTRL) begin
      a.write_data[7] = (k == 0);
      a.write_data[6] = (k == 1);
      if (k > 3) a.write_data[1:0] = 2'b01;
    end
    if (a.opcode == OP_REG_WR && a.reg_select == REG_ADDR && k < 7)
      a.write_data = $urandom_range(1) ? $urandom_range(127) : $urandom;
    if (mdl_busy != 0 && k < 6) a.opcode = OP_TICK;
    send_access(a);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      random_access();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 20; i++) send_op(OP_REG_RD, REG_STATUS, '0, '0);
    drain(8);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // handshake is stable at the falling edge; the transfer follows at the next rising edge
  always @(negedge clk) begin
    reply_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_data, out_ch.busy_res, out_ch.accepted};
      n_replies <= n_replies + 1;
      if (replies_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transfer %p", got);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch exp %p act %p", want, got);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.reg_select = '0;
    in_ch.flash_index = '0; in_ch.write_data = '0; out_ch.ready = 1'b0;
    for (int i = 0; i < FLASH_WORDS; i++) mdl_flash[i] = 16'hFFFF;
    mdl_key = KS_WAIT1; mdl_ctrl = '0; mdl_addr = '0; mdl_perr = 1'b0;
    mdl_busy = '0; mdl_eptr = '0; mdl_erase_ticks = 24'd4096; mdl_prog_ticks = 16'd4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 6; recv_idle_pct = 73;
    test_directed();
    test_program_erase();
    write_cfg(CFG_PROG_TICKS, 24'd3);
    write_cfg(CFG_ERASE_TICKS, 24'd1100);
    test_backpressure();
    test_random(130);
    drain(8);
    send_idle_pct = 73; recv_idle_pct = 6;
    write_cfg(CFG_PROG_TICKS, 24'd1);
    test_random(130);
    drain(8);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(140);
    tick_until_idle();
    test_wrong_key();
    drain(8);
    $display("Covered unlock, lock, erase, program, errors, busy gating and back-pressure;");
    $display("%0d replies checked, %0d mismatches.", n_replies, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

@@ flash_program_erase_controller.f @@
hdl/fpec_pkg.sv
hdl/fpec_if.sv
hdl/fpec_ram.sv
hdl/flash_program_erase_controller.sv
dv/fpec_tb_if.sv
dv/tb_flash_program_erase_controller.sv
